[design/pps_pkg.sv]
// Shared widths, register indexes and handshake structs for the pure pursuit steering block.
// No dependencies; every other design file refers to it by scoped names.
package pps_pkg;

    // Field widths
    localparam int PT_W  = 24;   // path point coordinate, signed Q8.16
    localparam int LA_W  = 23;   // lookahead radius, unsigned Q7.16
    localparam int SPD_W = 16;   // speeds, signed Q4.12
    localparam int CFG_W = 23;   // widest configuration register
    localparam int IDX_W = 2;    // configuration register index

    // Arithmetic widths
    localparam int MUL_W = 2 * PT_W;      // product of the shared multiplier
    localparam int MAG_W = 39;            // |v*y| fits in 39 bits
    localparam int NUM_W = 57;            // (|2*v*y| << 16) + den/2
    localparam int QB    = 15;            // quotient bits below the saturation point
    localparam int REM_W = MUL_W + QB;    // den << QB
    localparam int CNT_W = 4;             // divider step count (0..QB)

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_LOOKAHEAD = 2'd0;
    localparam logic [IDX_W-1:0] REG_SPEED     = 2'd1;
    localparam logic [IDX_W-1:0] REG_TURN_MAX  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [LA_W-1:0]  LOOKAHEAD_RST = 23'd26214;  // 0.4 m
    localparam logic [SPD_W-1:0] SPEED_RST     = 16'd819;    // 0.2 m/s
    localparam logic [SPD_W-1:0] TURN_MAX_RST  = 16'd4096;   // 1.0 rad/s

    // Divider status back to the sequencer
    typedef struct packed {
        logic          done;   // one-cycle pulse, result below is valid
        logic          sat;    // quotient reached 2^QB
        logic [QB-1:0] quo;
    } div_status_t;

endpackage

[design/pps_mul.sv]
// Shared signed multiplier with a registered product for the steering sequencer.
// Depends on pps_pkg for widths.
module pps_mul
(
    input  logic                                clk,
    input  logic signed [pps_pkg::PT_W-1:0]     a,
    input  logic signed [pps_pkg::PT_W-1:0]     b,
    output logic signed [pps_pkg::MUL_W-1:0]    p
);

    logic signed [pps_pkg::MUL_W-1:0] p_reg;

    // one product per cycle, registered
    always_ff @(posedge clk)
    begin
        p_reg <= pps_pkg::MUL_W'(a) * pps_pkg::MUL_W'(b);
    end

    assign p = p_reg;

endmodule

[design/pps_div.sv]
// Restoring divider, one quotient bit per cycle, with a saturation check on the first step.
// Depends on pps_pkg for widths and the status struct.
module pps_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pps_pkg::NUM_W-1:0]     num,
    input  logic [pps_pkg::MUL_W-1:0]     den,
    output pps_pkg::div_status_t          status
);

    logic                          busy_reg;
    logic                          done_reg;
    logic                          sat_reg;
    logic [pps_pkg::CNT_W-1:0]     cnt_reg;
    logic [pps_pkg::REM_W-1:0]     rem_reg;
    logic [pps_pkg::REM_W-1:0]     dsh_reg;
    logic [pps_pkg::QB-1:0]        quo_reg;
    logic                          ge;
    logic [pps_pkg::REM_W-1:0]     diff;

    // trial subtract of the shifted divisor
    assign ge   = (rem_reg >= dsh_reg);
    assign diff = rem_reg - dsh_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                // the first step ends the run when the quotient saturates
                if ((cnt_reg == '0 && ge) || cnt_reg == pps_pkg::CNT_W'(pps_pkg::QB))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= pps_pkg::REM_W'(num);
            dsh_reg <= {den, {pps_pkg::QB{1'b0}}};
            quo_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dsh_reg <= dsh_reg >> 1;
            if (cnt_reg == '0)
            begin
                sat_reg <= ge;
            end
            else
            begin
                if (ge)
                begin
                    rem_reg <= diff;
                end
                quo_reg <= {quo_reg[pps_pkg::QB-2:0], ge};
            end
        end
    end

    assign status.done = done_reg;
    assign status.sat  = sat_reg;
    assign status.quo  = quo_reg;

endmodule

[design/pure_pursuit_steering.sv]
// Top level of the pure pursuit steering block: sequencer, goal state and output beat register.
// Depends on pps_pkg, pps_mul and pps_div.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one path point per beat, already in the
//   robot frame. The block keeps the first point at or beyond the lookahead radius, else
//   the latest point. A beat with last_point set produces one output beat
//   (linear_speed, angular_speed) on out_valid / out_stall; other beats produce none.
//   A point without a goal keeps in_stall high while the shared multiplier forms x*x,
//   y*y and L*L and the compare follows. A final point adds v*y, a divider start, the
//   bit-serial divider (cut short when the quotient saturates) and the output state;
//   the divider is skipped if the goal is not ahead. With a goal held a non-final point
//   is taken without leaving the idle state.
//   in_stall is high while an item is being worked on.
//   The output register holds a finished command while the receiver stalls; the block
//   keeps accepting points meanwhile and only waits when a second command is ready.
//   Reset (rst_n, asynchronous) clears the goal, empties the output register and loads
//   the configuration registers with their defaults. The user writes configuration through
//   cfg_write / cfg_index / cfg_data only while the block is idle; the block does not enforce it.
module pure_pursuit_steering
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [pps_pkg::PT_W-1:0]     point_x,
    input  logic signed [pps_pkg::PT_W-1:0]     point_y,
    input  logic                                last_point,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pps_pkg::SPD_W-1:0]    linear_speed,
    output logic signed [pps_pkg::SPD_W-1:0]    angular_speed,
    // configuration
    input  logic                                cfg_write,
    input  logic [pps_pkg::IDX_W-1:0]           cfg_index,
    input  logic [pps_pkg::CFG_W-1:0]           cfg_data
);

    localparam int ANG_W = pps_pkg::SPD_W + 1;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQX  = 4'd1;
    localparam logic [3:0] S_SQY  = 4'd2;
    localparam logic [3:0] S_SQL  = 4'd3;
    localparam logic [3:0] S_CMP  = 4'd4;
    localparam logic [3:0] S_VY   = 4'd5;
    localparam logic [3:0] S_DIV0 = 4'd6;
    localparam logic [3:0] S_DIVW = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]                          state_reg;
    logic [3:0]                          state_next;

    // configuration registers
    logic [pps_pkg::LA_W-1:0]            lookahead_reg;
    logic signed [pps_pkg::SPD_W-1:0]    speed_reg;
    logic signed [pps_pkg::SPD_W-1:0]    turn_max_reg;

    // current point and goal
    logic signed [pps_pkg::PT_W-1:0]     pt_x_reg;
    logic signed [pps_pkg::PT_W-1:0]     pt_y_reg;
    logic                                last_reg;
    logic                                goal_found_reg;
    logic signed [pps_pkg::PT_W-1:0]     goal_x_reg;
    logic signed [pps_pkg::PT_W-1:0]     goal_y_reg;
    logic [pps_pkg::MUL_W-1:0]           goal_d2_reg;
    logic [pps_pkg::MUL_W-1:0]           acc_reg;

    // command under construction
    logic                                neg_reg;
    logic signed [ANG_W-1:0]             ang_reg;
    logic signed [pps_pkg::SPD_W-1:0]    lin_reg;

    // output beat register
    logic                                out_valid_reg;
    logic signed [pps_pkg::SPD_W-1:0]    lin_out_reg;
    logic signed [pps_pkg::SPD_W-1:0]    ang_out_reg;

    logic                                in_fire;
    logic                                slot_free;
    logic signed [pps_pkg::PT_W-1:0]     mul_a;
    logic signed [pps_pkg::PT_W-1:0]     mul_b;
    logic signed [pps_pkg::MUL_W-1:0]    mul_p;
    logic [pps_pkg::MUL_W-1:0]           mul_mag;
    logic [pps_pkg::NUM_W-1:0]           div_num;
    logic                                div_start;
    pps_pkg::div_status_t                div_st;
    logic                                goal_ahead;
    logic signed [ANG_W-1:0]             div_ang;
    logic signed [ANG_W-1:0]             lim;
    logic signed [ANG_W-1:0]             ang_clamped;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign goal_ahead = !goal_x_reg[pps_pkg::PT_W-1] && (goal_x_reg != '0);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = pt_x_reg;
        mul_b = pt_x_reg;
        unique case (state_reg)
            S_SQY:
            begin
                mul_a = pt_y_reg;
                mul_b = pt_y_reg;
            end
            S_SQL:
            begin
                mul_a = pps_pkg::PT_W'(lookahead_reg);
                mul_b = pps_pkg::PT_W'(lookahead_reg);
            end
            S_VY:
            begin
                mul_a = goal_y_reg;
                mul_b = pps_pkg::PT_W'(speed_reg);
            end
            default:
            begin
                mul_a = pt_x_reg;
                mul_b = pt_x_reg;
            end
        endcase
    end

    pps_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // divider numerator: (|v*y| << 17) + den/2
    assign mul_mag   = mul_p[pps_pkg::MUL_W-1] ? pps_pkg::MUL_W'(-mul_p)
                                               : pps_pkg::MUL_W'(mul_p);
    assign div_num   = {mul_mag[pps_pkg::MAG_W-1:0], 17'd0}
                     + pps_pkg::NUM_W'(goal_d2_reg >> 1);
    assign div_start = (state_reg == S_DIV0);

    pps_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (goal_d2_reg),
        .status (div_st)
    );

    // signed turn rate from the quotient, saturated to Q4.12
    always_comb
    begin
        if (div_st.sat)
        begin
            div_ang = neg_reg ? -ANG_W'(32768) : ANG_W'(32767);
        end
        else
        begin
            div_ang = neg_reg ? -ANG_W'(div_st.quo) : ANG_W'(div_st.quo);
        end
    end

    // clamp to +/- |max_turn_rate|
    assign lim = turn_max_reg[pps_pkg::SPD_W-1] ? -ANG_W'(turn_max_reg) : ANG_W'(turn_max_reg);
    always_comb
    begin
        priority if (ang_reg > lim)
        begin
            ang_clamped = lim;
        end
        else if (ang_reg < -lim)
        begin
            ang_clamped = -lim;
        end
        else
        begin
            ang_clamped = ang_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (!goal_found_reg)
                    begin
                        state_next = S_SQX;
                    end
                    else if (last_point)
                    begin
                        state_next = S_VY;
                    end
                end
            end
            S_SQX:  state_next = S_SQY;
            S_SQY:  state_next = S_SQL;
            S_SQL:  state_next = S_CMP;
            S_CMP:  state_next = last_reg ? S_VY : S_IDLE;
            S_VY:   state_next = goal_ahead ? S_DIV0 : S_OUT;
            S_DIV0: state_next = S_DIVW;
            S_DIVW: state_next = div_st.done ? S_OUT : S_DIVW;
            S_OUT:  state_next = slot_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            goal_found_reg <= 1'b0;
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            out_valid_reg  <= 1'b0;
            lookahead_reg  <= pps_pkg::LOOKAHEAD_RST;
            speed_reg      <= pps_pkg::SPEED_RST;
            turn_max_reg   <= pps_pkg::TURN_MAX_RST;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_write)
            begin
                unique case (cfg_index)
                    pps_pkg::REG_LOOKAHEAD: lookahead_reg <= cfg_data[pps_pkg::LA_W-1:0];
                    pps_pkg::REG_SPEED:     speed_reg     <= cfg_data[pps_pkg::SPD_W-1:0];
                    pps_pkg::REG_TURN_MAX:  turn_max_reg  <= cfg_data[pps_pkg::SPD_W-1:0];
                    default: ;
                endcase
            end

            // latch the point as goal; mark found once at or beyond the radius
            if (state_reg == S_CMP)
            begin
                goal_x_reg <= pt_x_reg;
                goal_y_reg <= pt_y_reg;
                if (acc_reg >= $unsigned(mul_p))
                begin
                    goal_found_reg <= 1'b1;
                end
            end

            // output beat register: load a new command, else drop an accepted beat
            if (state_reg == S_OUT && slot_free)
            begin
                out_valid_reg  <= 1'b1;
                goal_found_reg <= 1'b0;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pt_x_reg <= point_x;
            pt_y_reg <= point_y;
            last_reg <= last_point;
        end

        unique case (state_reg)
            S_SQY:  acc_reg <= $unsigned(mul_p);
            S_SQL:  acc_reg <= acc_reg + $unsigned(mul_p);
            S_CMP:  goal_d2_reg <= acc_reg;
            S_VY:
            begin
                if (goal_ahead)
                begin
                    lin_reg <= speed_reg;
                end
                else
                begin
                    lin_reg <= '0;
                    ang_reg <= ANG_W'(turn_max_reg);
                end
            end
            S_DIV0: neg_reg <= mul_p[pps_pkg::MUL_W-1];
            S_DIVW:
            begin
                if (div_st.done)
                begin
                    ang_reg <= div_ang;
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    lin_out_reg <= lin_reg;
                    ang_out_reg <= ang_clamped[pps_pkg::SPD_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign linear_speed  = lin_out_reg;
    assign angular_speed = ang_out_reg;

    // a command appears only from the output state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("output beat without a finished command");

    // the goal is released once its command is issued
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && slot_free) |=> !goal_found_reg)
        else $error("goal kept after end of path");

    // a point without a goal is always measured
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !goal_found_reg) |=> (state_reg == S_SQX))
        else $error("point accepted without distance test");

    // the divider reports only while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == S_DIVW))
        else $error("divider result outside of wait state");

endmodule
